// ===== design/primr_pkg.sv =====
// ----------------------------------------------------------------------------
// primr_pkg
// shared widths and defaults for the primitive root / modular inverse unit
// ----------------------------------------------------------------------------
`default_nettype none

package primr_pkg;

	parameter int WORD_W          = 32;
	parameter int DIV_STEPS       = 2 * WORD_W;
	parameter int MAX_FACTORS_DEF = 10;

	// request codes
	parameter logic REQ_ROOT = 1'b0;
	parameter logic REQ_INV  = 1'b1;

endpackage

`default_nettype wire

// ===== design/primr_div.sv =====
// ----------------------------------------------------------------------------
// primr_div
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module primr_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [2*primr_pkg::WORD_W-1:0]  dividend,
	input  wire logic [primr_pkg::WORD_W-1:0]    divisor,
	output logic                                 done,
	output logic [2*primr_pkg::WORD_W-1:0]       quotient,
	output logic [primr_pkg::WORD_W-1:0]         remainder
);
	import primr_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic                  running_q;
	logic [CNT_W-1:0]      step_q;
	logic [WORD_W-1:0]     acc_q;
	logic [2*WORD_W-1:0]   quo_q;
	logic [WORD_W-1:0]     dsr_q;

	logic [WORD_W:0]       trial;
	logic [WORD_W:0]       diff;
	logic                  ge;

	assign trial = {acc_q, quo_q[2*WORD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			step_q    <= '0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start && !running_q) begin
				running_q <= 1'b1;
				step_q    <= '0;
			end else if (running_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == CNT_W'(DIV_STEPS - 1)) begin
					running_q <= 1'b0;
					done      <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start && !running_q) begin
			acc_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (running_q) begin
			acc_q <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
			quo_q <= {quo_q[2*WORD_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign remainder = acc_q;

endmodule

`default_nettype wire

// ===== design/primitive_root_and_mod_inverse_unit.sv =====
// ----------------------------------------------------------------------------
// primitive_root_and_mod_inverse_unit
// finds a primitive root of a modulus or a Fermat inverse of a value
// ----------------------------------------------------------------------------
// channel   direction  ports                              handshake
// request   in         req_type, modulus, value           start & !busy
// result    out        answer                             done (one-cycle strobe)
//
// every divide/modulo runs on one shared bit-serial divider of 64 steps;
// a modular multiply is one registered 32x32 product plus one divide
// inverse: one divide per gcd step (at most ~46), one reduction, then up to 64
//   multiplies; a value sharing a factor ends after the gcd
// root: trial division up to sqrt(modulus-1), one squaring and one divide per
//   trial divisor and one more divide per extra division, then per candidate
//   and factor one exponentiation
// reset clears the control state only; results cannot be stalled, done is a
// single-cycle strobe and busy drops in that same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module primitive_root_and_mod_inverse_unit #(
	parameter int MAX_FACTORS = primr_pkg::MAX_FACTORS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          req_type,
	input  wire logic [primr_pkg::WORD_W-1:0]  modulus,
	input  wire logic [primr_pkg::WORD_W-1:0]  value,
	output logic                               done,
	output logic [primr_pkg::WORD_W-1:0]       answer
);
	import primr_pkg::*;

	localparam int CNT_W = $clog2(MAX_FACTORS + 1);
	localparam int IDX_W = $clog2(MAX_FACTORS);
	localparam int D_W   = WORD_W / 2 + 1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_R_SQ,   // trial divisor squared
		ST_R_CHK,  // d*d <= n ?
		ST_R_DIV,  // n / d
		ST_G_TOP,  // next candidate
		ST_K_TOP,  // next factor
		ST_K_DIV,  // phi / factor
		ST_P_TOP,  // exponent loop head
		ST_P_MR,   // r * base mod m
		ST_P_RW,
		ST_P_SQ,   // base * base mod m
		ST_P_SR,
		ST_P_SW,
		ST_I_GTOP, // gcd loop head
		ST_I_GDIV,
		ST_I_RED   // value mod m
	} state_t;

	state_t                 state_q;
	logic [WORD_W-1:0]      m_q;
	logic [WORD_W-1:0]      phi_q;
	logic [WORD_W-1:0]      n_q;
	logic [D_W-1:0]         d_q;
	logic                   found_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       k_q;
	logic [WORD_W-1:0]      fac_q [MAX_FACTORS];
	logic [WORD_W:0]        g_q;
	logic                   inv_q;
	logic [WORD_W-1:0]      exp_q;
	logic [WORD_W-1:0]      r_q;
	logic [WORD_W-1:0]      base_q;
	logic [WORD_W-1:0]      ga_q;
	logic [WORD_W-1:0]      gb_q;
	logic [2*WORD_W-1:0]    prod_q;

	logic [WORD_W-1:0]      mul_a;
	logic [WORD_W-1:0]      mul_b;
	logic                   div_start;
	logic [2*WORD_W-1:0]    div_dividend;
	logic [WORD_W-1:0]      div_divisor;
	logic                   div_done;
	logic [2*WORD_W-1:0]    div_quo;
	logic [WORD_W-1:0]      div_rem;
	logic                   fac_room;

	assign busy     = (state_q != ST_IDLE);
	assign fac_room = (cnt_q < CNT_W'(MAX_FACTORS));

	primr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// multiplier operand select, product is registered in prod_q
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_R_SQ: begin
				mul_a = WORD_W'(d_q);
				mul_b = WORD_W'(d_q);
			end
			ST_P_TOP: begin
				mul_a = r_q;
				mul_b = base_q;
			end
			ST_P_SQ: begin
				mul_a = base_q;
				mul_b = base_q;
			end
			default: begin
			end
		endcase
	end

	// divider launch
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = m_q;
		case (state_q)
			ST_R_CHK: begin
				div_start    = (prod_q <= {{WORD_W{1'b0}}, n_q});
				div_dividend = {{WORD_W{1'b0}}, n_q};
				div_divisor  = WORD_W'(d_q);
			end
			ST_R_DIV: begin
				// keep dividing while d still divides n
				div_start    = div_done && (div_rem == '0);
				div_dividend = {{WORD_W{1'b0}}, div_quo[WORD_W-1:0]};
				div_divisor  = WORD_W'(d_q);
			end
			ST_K_TOP: begin
				div_start    = (k_q != cnt_q);
				div_dividend = {{WORD_W{1'b0}}, phi_q};
				div_divisor  = fac_q[k_q[IDX_W-1:0]];
			end
			ST_P_MR, ST_P_SR: begin
				div_start    = 1'b1;
				div_dividend = prod_q;
			end
			ST_I_GTOP: begin
				if (ga_q != '0) begin
					div_start    = 1'b1;
					div_dividend = {{WORD_W{1'b0}}, gb_q};
					div_divisor  = ga_q;
				end else begin
					// gcd found: if it is one, reduce the value, still held in base_q
					div_start    = (gb_q == WORD_W'(1));
					div_dividend = {{WORD_W{1'b0}}, base_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
			k_q     <= '0;
			found_q <= 1'b0;
			inv_q   <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						m_q   <= modulus;
						phi_q <= modulus - WORD_W'(1);
						n_q   <= modulus - WORD_W'(1);
						d_q   <= D_W'(2);
						cnt_q <= '0;
						found_q <= 1'b0;
						inv_q <= (req_type == REQ_INV);
						ga_q  <= value;
						gb_q  <= modulus;
						base_q <= value;
						if (modulus < WORD_W'(2)) begin
							answer  <= '0;
							done    <= 1'b1;
						end else if (req_type == REQ_INV) begin
							state_q <= ST_I_GTOP;
						end else begin
							state_q <= ST_R_SQ;
						end
					end
				end
				ST_R_SQ: state_q <= ST_R_CHK;
				ST_R_CHK: begin
					if (prod_q <= {{WORD_W{1'b0}}, n_q}) begin
						state_q <= ST_R_DIV;
					end else begin
						if (n_q > WORD_W'(1) && fac_room) begin
							fac_q[cnt_q[IDX_W-1:0]] <= n_q;
							cnt_q <= cnt_q + 1'b1;
						end
						g_q     <= (WORD_W+1)'(2);
						state_q <= ST_G_TOP;
					end
				end
				ST_R_DIV: begin
					if (div_done) begin
						if (div_rem == '0) begin
							if (!found_q && fac_room) begin
								fac_q[cnt_q[IDX_W-1:0]] <= WORD_W'(d_q);
								cnt_q <= cnt_q + 1'b1;
							end
							found_q <= 1'b1;
							n_q     <= div_quo[WORD_W-1:0];
						end else begin
							d_q     <= d_q + 1'b1;
							found_q <= 1'b0;
							state_q <= ST_R_SQ;
						end
					end
				end
				ST_G_TOP: begin
					if (g_q > {1'b0, m_q}) begin
						answer  <= '0;
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						k_q     <= '0;
						state_q <= ST_K_TOP;
					end
				end
				ST_K_TOP: begin
					if (k_q == cnt_q) begin
						answer  <= g_q[WORD_W-1:0];
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_K_DIV;
					end
				end
				ST_K_DIV: begin
					if (div_done) begin
						exp_q   <= div_quo[WORD_W-1:0];
						base_q  <= (g_q == {1'b0, m_q}) ? '0 : g_q[WORD_W-1:0];
						r_q     <= WORD_W'(1);
						state_q <= ST_P_TOP;
					end
				end
				ST_P_TOP: begin
					if (exp_q == '0) begin
						if (inv_q) begin
							answer  <= r_q;
							done    <= 1'b1;
							state_q <= ST_IDLE;
						end else if (r_q == WORD_W'(1)) begin
							g_q     <= g_q + 1'b1;
							state_q <= ST_G_TOP;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_K_TOP;
						end
					end else if (exp_q[0]) begin
						state_q <= ST_P_MR;
					end else begin
						state_q <= ST_P_SQ;
					end
				end
				ST_P_MR: state_q <= ST_P_RW;
				ST_P_RW: begin
					if (div_done) begin
						r_q     <= div_rem;
						state_q <= ST_P_SQ;
					end
				end
				ST_P_SQ: state_q <= ST_P_SR;
				ST_P_SR: state_q <= ST_P_SW;
				ST_P_SW: begin
					if (div_done) begin
						base_q  <= div_rem;
						exp_q   <= exp_q >> 1;
						state_q <= ST_P_TOP;
					end
				end
				ST_I_GTOP: begin
					if (ga_q != '0) begin
						state_q <= ST_I_GDIV;
					end else if (gb_q == WORD_W'(1)) begin
						state_q <= ST_I_RED;
					end else begin
						answer  <= '0;
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_I_GDIV: begin
					if (div_done) begin
						gb_q    <= ga_q;
						ga_q    <= div_rem;
						state_q <= ST_I_GTOP;
					end
				end
				ST_I_RED: begin
					if (div_done) begin
						base_q  <= div_rem;
						r_q     <= WORD_W'(1);
						exp_q   <= m_q - WORD_W'(2);
						state_q <= ST_P_TOP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// product register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

`ifndef SYNTHESIS
	// the result strobe comes with the unit back at rest
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");

	// an accepted item either finishes at once or keeps the unit busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item lost");

	// factor list never overflows
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FACTORS))
		else $error("factor count overflow");

	// factor walk stays within the recorded list
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_K_DIV) |-> (k_q < cnt_q))
		else $error("factor index out of range");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the primitive root / modular inverse unit: requests are predicted
// with a bit-exact software model and each answer is compared in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	import primr_pkg::*;

	typedef struct {
		logic              kind;
		logic [WORD_W-1:0] modv;
		logic [WORD_W-1:0] val;
	} request_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              req_type;
	logic [WORD_W-1:0] modulus;
	logic [WORD_W-1:0] value;
	logic              done;
	logic [WORD_W-1:0] answer;

	request_t          pending_reqs[$];
	logic [WORD_W-1:0] expected_answers[$];
	int                gap_left;
	int                errors;

	primitive_root_and_mod_inverse_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req_type(req_type),
		.modulus (modulus),
		.value   (value),
		.done    (done),
		.answer  (answer)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// square-and-multiply with 64-bit products, as the unit does it
	function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		logic [63:0] r;
		if (m == 0) return 0;
		b = b % m;
		r = 1 % m;
		while (e != 0) begin
			if (e[0]) r = (r * b) % m;
			b = (b * b) % m;
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
		logic [63:0] t;
		while (a != 0) begin
			t = b % a;
			b = a;
			a = t;
		end
		return b;
	endfunction

	function automatic logic [WORD_W-1:0] primitive_root(logic [63:0] m);
		logic [63:0] factors[MAX_FACTORS_DEF];
		int          cnt;
		logic [63:0] phi, n, d, g;
		bit          good;
		cnt = 0;
		if (m < 2) return 0;
		phi = m - 1;
		n = phi;
		for (d = 2; d * d <= n; d++) begin
			if (n % d == 0) begin
				if (cnt < MAX_FACTORS_DEF) begin
					factors[cnt] = d;
					cnt++;
				end
				while (n % d == 0) n = n / d;
			end
		end
		if (n > 1 && cnt < MAX_FACTORS_DEF) begin
			factors[cnt] = n;
			cnt++;
		end
		for (g = 2; g <= m; g++) begin
			good = 1;
			for (int k = 0; k < cnt && good; k++)
				if (pow_mod(g, phi / factors[k], m) == 1) good = 0;
			if (good) return g[WORD_W-1:0];
		end
		return 0;
	endfunction

	function automatic logic [WORD_W-1:0] fermat_inverse(logic [63:0] a, logic [63:0] m);
		if (m < 2) return 0;
		if (gcd64(a, m) != 1) return 0;
		return WORD_W'(pow_mod(a, m - 2, m));
	endfunction

	function automatic logic [WORD_W-1:0] predict_answer(request_t r);
		if (r.kind == REQ_ROOT) return primitive_root(r.modv);
		return fermat_inverse(r.val, r.modv);
	endfunction

	function automatic bit is_prime(logic [31:0] n);
		if (n < 2) return 0;
		for (logic [31:0] d = 2; d * d <= n; d++)
			if (n % d == 0) return 0;
		return 1;
	endfunction

	function automatic logic [31:0] rand_prime(logic [31:0] hi);
		logic [31:0] p;
		do p = $urandom_range(hi, 2); while (!is_prime(p));
		return p;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(9, 0) == 0) return $urandom_range(60, 10);
		if ($urandom_range(3, 0) == 0) return 0;
		return $urandom_range(3, 0);
	endfunction

	task automatic add_req(logic kind, logic [31:0] m, logic [31:0] v);
		request_t r;
		r.kind = kind;
		r.modv = m;
		r.val  = v;
		pending_reqs.push_back(r);
	endtask

	// driver: start stays up until the unit takes the item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			req_type <= REQ_ROOT;
			modulus  <= '0;
			value    <= '0;
			gap_left <= 0;
		end else begin
			// item taken at this edge
			if (start && !busy) begin
				expected_answers.push_back(predict_answer(pending_reqs.pop_front()));
				gap_left <= pick_gap();
				start    <= 1'b0;
			end else if (!start) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() > 0) begin
					start    <= 1'b1;
					req_type <= pending_reqs[0].kind;
					modulus  <= pending_reqs[0].modv;
					value    <= pending_reqs[0].val;
				end
			end
		end
	end

	// monitor: done is a one-cycle strobe, nothing can hold it off
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				$error("answer %0d with no request outstanding", answer);
				errors++;
			end else begin
				logic [WORD_W-1:0] exp_ans;
				exp_ans = expected_answers.pop_front();
				if (answer !== exp_ans) begin
					$error("answer: expected %0d, got %0d", exp_ans, answer);
					errors++;
				end
			end
		end
	end

	initial begin
		int          n;
		logic [31:0] m;
		errors    = 0;
		arst_n    = 1'b0;
		// directed: special cases and field extremes
		add_req(REQ_ROOT, 2, 32'hFFFF_FFFF);
		add_req(REQ_ROOT, 3, 0);
		add_req(REQ_ROOT, 0, 0);
		add_req(REQ_ROOT, 1, 0);
		add_req(REQ_INV, 0, 5);
		add_req(REQ_INV, 1, 5);
		add_req(REQ_INV, 2, 1);
		add_req(REQ_INV, 7, 0);
		add_req(REQ_INV, 7, 3);
		add_req(REQ_INV, 7, 14);
		add_req(REQ_INV, 7, 32'hFFFF_FFFF);
		add_req(REQ_INV, 32'hFFFF_FFFB, 32'hFFFF_FFFF);
		add_req(REQ_INV, 32'hFFFF_FFFB, 32'h8000_0000);
		add_req(REQ_INV, 32'hFFFF_FFFF, 32'h1234_5678);
		add_req(REQ_INV, 32'hFFFF_FFFF, 3);
		add_req(REQ_INV, 15, 4);
		add_req(REQ_ROOT, 4, 0);
		add_req(REQ_ROOT, 15, 0);
		add_req(REQ_ROOT, 91, 0);
		add_req(REQ_ROOT, 41, 0);
		add_req(REQ_ROOT, 65537, 0);
		// the largest root case: trial division of a 32-bit modulus
		add_req(REQ_ROOT, 32'hFFFF_FFFB, 0);
		// random: mostly prime moduli with small sizes for root requests
		for (int i = 0; i < 100; i++) begin
			n = $urandom_range(99, 0);
			if (n < 35) begin
				m = ($urandom_range(4, 0) == 0) ? $urandom_range(4095, 0) : rand_prime(4095);
				add_req(REQ_ROOT, m, $urandom());
			end else if (n < 45) begin
				add_req(REQ_ROOT, rand_prime(200000), $urandom());
			end else if (n < 85) begin
				m = ($urandom_range(4, 0) == 0) ? $urandom() : rand_prime(65535);
				add_req(REQ_INV, m, $urandom());
			end else begin
				// large modulus, value sometimes a multiple of it
				m = $urandom() | 32'h8000_0000;
				add_req(REQ_INV, m, ($urandom_range(3, 0) == 0) ? m : $urandom());
			end
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && !start);
		wait (expected_answers.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog: far above the slowest correct run
	initial begin
		#(64'd800_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
